[sv/mfd_pkg.sv]
// Shared definitions for the magnetometer frame decoder: operation and
// register codes, fixed widths, and the CORDIC arctangent table.
// No dependencies.
package mfd_pkg;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_FORGET = 2'd2
  } op_e;

  typedef enum logic {
    REG_MODE = 1'b0,
    REG_NULL = 1'b1
  } reg_idx_e;

  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned ANGLE_TABLE_LEN  = 24;

  localparam int unsigned RAW_W   = 20;
  localparam int unsigned FIELD_W = 21;
  localparam int unsigned AZ_W    = 16;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned XY_W    = 32;
  localparam int unsigned ACC_W   = 25;
  localparam int unsigned IDX_W   = 5;

  localparam logic [RAW_W-1:0]        NULL_OFFSET_RST = 20'd524288;
  localparam logic signed [ACC_W-1:0] QUARTER_TURN    = 25'sd2949120;
  localparam logic signed [AZ_W-1:0]  AZ_LIMIT        = 16'sd23040;

  // Arctangent of 2^-i in units of 1/32768 degree, rounded to nearest.
  function automatic logic signed [ACC_W-1:0] atan_angle(input logic [IDX_W-1:0] idx);
    logic signed [ACC_W-1:0] a;
    unique case (idx)
      5'd0:    a = 25'sd1474560;
      5'd1:    a = 25'sd870484;
      5'd2:    a = 25'sd459940;
      5'd3:    a = 25'sd233473;
      5'd4:    a = 25'sd117189;
      5'd5:    a = 25'sd58652;
      5'd6:    a = 25'sd29333;
      5'd7:    a = 25'sd14667;
      5'd8:    a = 25'sd7334;
      5'd9:    a = 25'sd3667;
      5'd10:   a = 25'sd1833;
      5'd11:   a = 25'sd917;
      5'd12:   a = 25'sd458;
      5'd13:   a = 25'sd229;
      5'd14:   a = 25'sd115;
      5'd15:   a = 25'sd57;
      5'd16:   a = 25'sd29;
      5'd17:   a = 25'sd14;
      5'd18:   a = 25'sd7;
      5'd19:   a = 25'sd4;
      5'd20:   a = 25'sd2;
      5'd21:   a = 25'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

[sv/magnetometer_frame_decoder.sv]
// Magnetometer frame decoder top level: frame unpacking, duplicate and error
// bookkeeping, and a pipelined CORDIC azimuth. Depends on mfd_pkg.
//
// The input channel carries one word per burst read: an op code, a bus error
// flag and the eight frame bytes. The output channel carries one result word
// per input word: accepted and duplicate flags, the three signed axis counts,
// the azimuth in 1/128 degree and both counter totals. Both channels move a
// word at a clock edge where valid is high and stall is low.
// The configuration channel writes continuous mode (index 0) and the null
// offset (index 1) at an edge where cfg_valid_i and cfg_ready_o are high; it
// is always ready and should only be written while the block is idle.
// A word is decoded and the counters and last frame are updated in the cycle
// it is accepted. The azimuth then runs through one CORDIC iteration per
// pipeline stage and then through the output register. One word is accepted
// every cycle while the output is not stalled. When the receiver stalls a
// waiting result, the whole pipeline holds and in_stall_o is raised. Reset
// empties the pipeline, clears both counters and the last-frame flag, turns
// continuous mode off and sets the offset to 524288.
module magnetometer_frame_decoder #(
  parameter int unsigned CORDIC_STEPS = mfd_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         op_i,
  input  logic                               bus_error_i,
  input  logic [7:0]                         x_high_byte_i,
  input  logic [7:0]                         x_mid_byte_i,
  input  logic [7:0]                         y_high_byte_i,
  input  logic [7:0]                         y_mid_byte_i,
  input  logic [7:0]                         z_high_byte_i,
  input  logic [7:0]                         z_mid_byte_i,
  input  logic [7:0]                         xy_low_nibbles_i,
  input  logic [7:0]                         z_low_nibble_byte_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic                               cfg_index_i,
  input  logic [mfd_pkg::RAW_W-1:0]          cfg_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               accepted_o,
  output logic                               duplicate_o,
  output logic signed [mfd_pkg::FIELD_W-1:0] field_x_o,
  output logic signed [mfd_pkg::FIELD_W-1:0] field_y_o,
  output logic signed [mfd_pkg::FIELD_W-1:0] field_z_o,
  output logic signed [mfd_pkg::AZ_W-1:0]    azimuth_o,
  output logic [mfd_pkg::CNT_W-1:0]          error_total_o,
  output logic [mfd_pkg::CNT_W-1:0]          duplicate_total_o
);
  import mfd_pkg::*;

  localparam int unsigned NSTEPS =
      (CORDIC_STEPS > ANGLE_TABLE_LEN) ? ANGLE_TABLE_LEN : CORDIC_STEPS;

  typedef struct packed {
    logic                      accepted;
    logic                      duplicate;
    logic signed [FIELD_W-1:0] fx;
    logic signed [FIELD_W-1:0] fy;
    logic signed [FIELD_W-1:0] fz;
    logic [CNT_W-1:0]          err_tot;
    logic [CNT_W-1:0]          dup_tot;
    logic                      az_fixed;
    logic signed [AZ_W-1:0]    az_fixed_val;
    logic signed [XY_W-1:0]    x;
    logic signed [XY_W-1:0]    y;
    logic signed [ACC_W-1:0]   acc;
  } stage_t;

  logic                mode_q;
  logic [RAW_W-1:0]    null_q;
  logic [RAW_W-1:0]    last_x_q, last_y_q, last_z_q;
  logic                last_valid_q, last_valid_d;
  logic [CNT_W-1:0]    err_cnt_q, err_cnt_d;
  logic [CNT_W-1:0]    dup_cnt_q, dup_cnt_d;
  logic                store_last;
  logic                adv, in_acc;
  logic [RAW_W-1:0]    raw_x, raw_y, raw_z;
  logic signed [FIELD_W-1:0] sx, sy, sz;
  logic signed [XY_W-1:0]    x_sc, y_sc;
  stage_t              dec;
  stage_t              pipe_q [NSTEPS+1];
  logic [NSTEPS:0]     vld_q;
  stage_t              fin;
  logic                out_vld_q;
  logic signed [ACC_W-1:0]   acc_rnd;
  logic signed [ACC_W-9:0]   az_wide;
  logic signed [AZ_W-1:0]    az_clamped;
  logic                      accepted_q, duplicate_q;
  logic signed [FIELD_W-1:0] fx_q, fy_q, fz_q;
  logic signed [AZ_W-1:0]    az_q;
  logic [CNT_W-1:0]          err_tot_q, dup_tot_q;

  assign adv         = !out_vld_q || !out_stall_i;
  assign in_stall_o  = !adv;
  assign in_acc      = in_valid_i && adv;
  assign cfg_ready_o = 1'b1;

  assign raw_x = {x_high_byte_i, x_mid_byte_i, xy_low_nibbles_i[7:4]};
  assign raw_y = {y_high_byte_i, y_mid_byte_i, xy_low_nibbles_i[3:0]};
  assign raw_z = {z_high_byte_i, z_mid_byte_i, z_low_nibble_byte_i[7:4]};
  assign sx    = $signed({1'b0, raw_x}) - $signed({1'b0, null_q});
  assign sy    = $signed({1'b0, raw_y}) - $signed({1'b0, null_q});
  assign sz    = $signed({1'b0, raw_z}) - $signed({1'b0, null_q});
  assign x_sc  = $signed({{(XY_W-FIELD_W-8){sx[FIELD_W-1]}}, sx, 8'd0});
  assign y_sc  = $signed({{(XY_W-FIELD_W-8){sy[FIELD_W-1]}}, sy, 8'd0});

  always_comb begin
    err_cnt_d    = err_cnt_q;
    dup_cnt_d    = dup_cnt_q;
    last_valid_d = last_valid_q;
    store_last   = 1'b0;
    dec          = '0;
    dec.az_fixed = 1'b1;
    unique case (op_e'(op_i))
      OP_CLEAR: begin
        err_cnt_d = '0;
        dup_cnt_d = '0;
      end
      OP_FORGET: begin
        last_valid_d = 1'b0;
      end
      OP_SAMPLE: begin
        if (bus_error_i) begin
          if (mode_q && err_cnt_q != '1) begin
            err_cnt_d = err_cnt_q + 1'b1;
          end
        end else if (mode_q && last_valid_q && raw_x == last_x_q &&
                     raw_y == last_y_q && raw_z == last_z_q) begin
          dec.duplicate = 1'b1;
          if (dup_cnt_q != '1) begin
            dup_cnt_d = dup_cnt_q + 1'b1;
          end
        end else begin
          dec.accepted = 1'b1;
          dec.fx       = sx;
          dec.fy       = sy;
          dec.fz       = sz;
          if (mode_q) begin
            store_last   = 1'b1;
            last_valid_d = 1'b1;
          end
          dec.az_fixed = (sy == '0);
          if (sx[FIELD_W-1]) begin
            dec.az_fixed_val = AZ_LIMIT;
          end
          if (!sx[FIELD_W-1]) begin
            dec.x = x_sc;
            dec.y = y_sc;
          end else if (!sy[FIELD_W-1]) begin
            dec.x   = y_sc;
            dec.y   = -x_sc;
            dec.acc = QUARTER_TURN;
          end else begin
            dec.x   = -y_sc;
            dec.y   = x_sc;
            dec.acc = -QUARTER_TURN;
          end
        end
      end
      default: begin
      end
    endcase
    dec.err_tot = err_cnt_d;
    dec.dup_tot = dup_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= 1'b0;
      null_q       <= NULL_OFFSET_RST;
      last_valid_q <= 1'b0;
      err_cnt_q    <= '0;
      dup_cnt_q    <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (reg_idx_e'(cfg_index_i))
          REG_MODE: mode_q <= cfg_data_i[0];
          REG_NULL: null_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        last_valid_q <= last_valid_d;
        err_cnt_q    <= err_cnt_d;
        dup_cnt_q    <= dup_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && store_last) begin
      last_x_q <= raw_x;
      last_y_q <= raw_y;
      last_z_q <= raw_z;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pipe_q[0] <= dec;
    end
  end

  for (genvar i = 0; i < NSTEPS; i++) begin : g_iter
    stage_t                  nxt;
    logic signed [XY_W-1:0]  xs, ys;
    logic signed [ACC_W-1:0] ang;

    assign xs  = pipe_q[i].x >>> i;
    assign ys  = pipe_q[i].y >>> i;
    assign ang = atan_angle(IDX_W'(i));

    always_comb begin
      nxt = pipe_q[i];
      if (!pipe_q[i].y[XY_W-1]) begin
        nxt.x   = pipe_q[i].x + ys;
        nxt.y   = pipe_q[i].y - xs;
        nxt.acc = pipe_q[i].acc + ang;
      end else begin
        nxt.x   = pipe_q[i].x - ys;
        nxt.y   = pipe_q[i].y + xs;
        nxt.acc = pipe_q[i].acc - ang;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        pipe_q[i+1] <= nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[NSTEPS-1:0], in_valid_i};
      out_vld_q <= vld_q[NSTEPS];
    end
  end

  assign fin     = pipe_q[NSTEPS];
  assign acc_rnd = fin.acc + ACC_W'(128);
  assign az_wide = acc_rnd[ACC_W-1:8];

  always_comb begin
    if (az_wide > (ACC_W-8)'(AZ_LIMIT)) begin
      az_clamped = AZ_LIMIT;
    end else if (az_wide < -(ACC_W-8)'(AZ_LIMIT)) begin
      az_clamped = -AZ_LIMIT;
    end else begin
      az_clamped = az_wide[AZ_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      accepted_q  <= fin.accepted;
      duplicate_q <= fin.duplicate;
      fx_q        <= fin.fx;
      fy_q        <= fin.fy;
      fz_q        <= fin.fz;
      err_tot_q   <= fin.err_tot;
      dup_tot_q   <= fin.dup_tot;
      az_q        <= fin.az_fixed ? fin.az_fixed_val : az_clamped;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign accepted_o        = accepted_q;
  assign duplicate_o       = duplicate_q;
  assign field_x_o         = fx_q;
  assign field_y_o         = fy_q;
  assign field_z_o         = fz_q;
  assign azimuth_o         = az_q;
  assign error_total_o     = err_tot_q;
  assign duplicate_total_o = dup_tot_q;

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for magnetometer_frame_decoder: a scoreboard package
// that predicts every result word, and the tb top that drives and samples it.
// Depends on mfd_pkg and the decoder RTL.
package mfd_check_pkg;
  import mfd_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned AZ_STEPS = 16;
  localparam longint AZ_MAX = 23040;
  localparam longint RIGHT_ANGLE = 2949120;
  localparam longint ANGLE_STEP [24] = '{
    1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
    7334, 3667, 1833, 917, 458, 229, 115, 57,
    29, 14, 7, 4, 2, 1, 0, 0
  };

  typedef struct packed {
    logic [1:0] op;
    logic       bus_error;
    logic [7:0] x_high;
    logic [7:0] x_mid;
    logic [7:0] y_high;
    logic [7:0] y_mid;
    logic [7:0] z_high;
    logic [7:0] z_mid;
    logic [7:0] xy_low;
    logic [7:0] z_low;
  } frame_t;

  typedef struct packed {
    logic                      accepted;
    logic                      duplicate;
    logic signed [FIELD_W-1:0] field_x;
    logic signed [FIELD_W-1:0] field_y;
    logic signed [FIELD_W-1:0] field_z;
    logic signed [AZ_W-1:0]    azimuth;
    logic [CNT_W-1:0]          error_total;
    logic [CNT_W-1:0]          duplicate_total;
  } sample_t;

  class frame_scoreboard;
    bit               continuous;
    logic [RAW_W-1:0] null_offset;
    logic [RAW_W-1:0] last_x, last_y, last_z;
    bit               last_valid;
    logic [CNT_W-1:0] error_count, duplicate_count;
    sample_t          expected_samples[$];
    int               fail_count;

    function new();
      continuous = 1'b0;
      null_offset = NULL_OFFSET_RST;
      last_x = '0;
      last_y = '0;
      last_z = '0;
      last_valid = 1'b0;
      error_count = '0;
      duplicate_count = '0;
      fail_count = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [RAW_W-1:0] data);
      if (idx == REG_MODE) continuous = data[0];
      else null_offset = data;
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction

    function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
      return (c == '1) ? c : c + 1'b1;
    endfunction

    function longint azimuth_of(longint fx, longint fy);
      longint x, y, acc, t, xs, ys, r;
      if (fy == 0) return (fx < 0) ? AZ_MAX : 0;
      x = fx * 256;
      y = fy * 256;
      acc = 0;
      if (x < 0) begin
        if (y > 0) begin
          t = x; x = y; y = -t; acc = RIGHT_ANGLE;
        end else begin
          t = x; x = -y; y = t; acc = -RIGHT_ANGLE;
        end
      end
      for (int i = 0; i < AZ_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys; y = y - xs; acc += ANGLE_STEP[i];
        end else begin
          x = x - ys; y = y + xs; acc -= ANGLE_STEP[i];
        end
      end
      r = (acc + 128) >>> 8;
      if (r > AZ_MAX) r = AZ_MAX;
      if (r < -AZ_MAX) r = -AZ_MAX;
      return r;
    endfunction

    function void note_frame(frame_t f);
      sample_t s;
      logic [RAW_W-1:0] rx, ry, rz;
      longint sx, sy, sz, az;
      s = '0;
      rx = {f.x_high, f.x_mid, f.xy_low[7:4]};
      ry = {f.y_high, f.y_mid, f.xy_low[3:0]};
      rz = {f.z_high, f.z_mid, f.z_low[7:4]};
      if (f.op == OP_CLEAR) begin
        error_count = '0;
        duplicate_count = '0;
      end else if (f.op == OP_FORGET) begin
        last_valid = 1'b0;
      end else if (f.op == OP_SAMPLE) begin
        if (f.bus_error) begin
          if (continuous) error_count = bump(error_count);
        end else if (continuous && last_valid && rx == last_x && ry == last_y &&
                     rz == last_z) begin
          duplicate_count = bump(duplicate_count);
          s.duplicate = 1'b1;
        end else begin
          sx = longint'(rx) - longint'(null_offset);
          sy = longint'(ry) - longint'(null_offset);
          sz = longint'(rz) - longint'(null_offset);
          if (continuous) begin
            last_x = rx;
            last_y = ry;
            last_z = rz;
            last_valid = 1'b1;
          end
          az = azimuth_of(sx, sy);
          s.accepted = 1'b1;
          s.field_x = sx[FIELD_W-1:0];
          s.field_y = sy[FIELD_W-1:0];
          s.field_z = sz[FIELD_W-1:0];
          s.azimuth = az[AZ_W-1:0];
        end
      end
      s.error_total = error_count;
      s.duplicate_total = duplicate_count;
      expected_samples.push_back(s);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
    endtask

    task check_sample(sample_t got);
      sample_t exp;
      if (expected_samples.size() == 0) begin
        report("result word with no expectation waiting");
        return;
      end
      exp = expected_samples.pop_front();
      if (got.accepted !== exp.accepted)
        report($sformatf("accepted %0b, expected %0b", got.accepted, exp.accepted));
      if (got.duplicate !== exp.duplicate)
        report($sformatf("duplicate %0b, expected %0b", got.duplicate, exp.duplicate));
      if (got.field_x !== exp.field_x)
        report($sformatf("field_x %0d, expected %0d", got.field_x, exp.field_x));
      if (got.field_y !== exp.field_y)
        report($sformatf("field_y %0d, expected %0d", got.field_y, exp.field_y));
      if (got.field_z !== exp.field_z)
        report($sformatf("field_z %0d, expected %0d", got.field_z, exp.field_z));
      if (got.azimuth !== exp.azimuth)
        report($sformatf("azimuth %0d, expected %0d", got.azimuth, exp.azimuth));
      if (got.error_total !== exp.error_total)
        report($sformatf("error_total %0d, expected %0d", got.error_total,
                         exp.error_total));
      if (got.duplicate_total !== exp.duplicate_total)
        report($sformatf("duplicate_total %0d, expected %0d", got.duplicate_total,
                         exp.duplicate_total));
    endtask
  endclass
endpackage

module tb;
  import mfd_pkg::*;
  import mfd_check_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_WORDS = 300;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic [1:0]                op_i = OP_SAMPLE;
  logic                      bus_error_i = 1'b0;
  logic [7:0]                x_high_byte_i = '0;
  logic [7:0]                x_mid_byte_i = '0;
  logic [7:0]                y_high_byte_i = '0;
  logic [7:0]                y_mid_byte_i = '0;
  logic [7:0]                z_high_byte_i = '0;
  logic [7:0]                z_mid_byte_i = '0;
  logic [7:0]                xy_low_nibbles_i = '0;
  logic [7:0]                z_low_nibble_byte_i = '0;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic                      cfg_index_i = 1'b0;
  logic [RAW_W-1:0]          cfg_data_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic                      accepted_o;
  logic                      duplicate_o;
  logic signed [FIELD_W-1:0] field_x_o;
  logic signed [FIELD_W-1:0] field_y_o;
  logic signed [FIELD_W-1:0] field_z_o;
  logic signed [AZ_W-1:0]    azimuth_o;
  logic [CNT_W-1:0]          error_total_o;
  logic [CNT_W-1:0]          duplicate_total_o;

  frame_scoreboard sb;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  int              cycle_count = 0;
  frame_t          last_sample;
  bit              have_last = 1'b0;

  magnetometer_frame_decoder DUT (.*);

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) out_stall_i <= rst_ni && ($urandom_range(99) < recv_idle_pct);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_sample({accepted_o, duplicate_o, field_x_o, field_y_o, field_z_o,
                       azimuth_o, error_total_o, duplicate_total_o});
  end

  function automatic frame_t pack_frame(logic [1:0] op, logic err, logic [RAW_W-1:0] rx,
                                        logic [RAW_W-1:0] ry, logic [RAW_W-1:0] rz,
                                        logic [3:0] pad);
    frame_t f;
    f.op = op;
    f.bus_error = err;
    f.x_high = rx[19:12];
    f.x_mid = rx[11:4];
    f.y_high = ry[19:12];
    f.y_mid = ry[11:4];
    f.z_high = rz[19:12];
    f.z_mid = rz[11:4];
    f.xy_low = {rx[3:0], ry[3:0]};
    f.z_low = {rz[3:0], pad};
    return f;
  endfunction

  function automatic logic [RAW_W-1:0] pick_axis(logic [RAW_W-1:0] ofs);
    case ($urandom_range(9))
      0: return ofs;
      1: return '0;
      2: return '1;
      3: return ofs + RAW_W'($urandom_range(32)) - RAW_W'(16);
      default: return RAW_W'($urandom);
    endcase
  endfunction

  task automatic send_word(frame_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= f.op;
    bus_error_i <= f.bus_error;
    x_high_byte_i <= f.x_high;
    x_mid_byte_i <= f.x_mid;
    y_high_byte_i <= f.y_high;
    y_mid_byte_i <= f.y_mid;
    z_high_byte_i <= f.z_high;
    z_mid_byte_i <= f.z_mid;
    xy_low_nibbles_i <= f.xy_low;
    z_low_nibble_byte_i <= f.z_low;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_frame(f);
    if (f.op == OP_SAMPLE && !f.bus_error) begin
      last_sample = f;
      have_last = 1'b1;
    end
  endtask

  task automatic send_sample(logic [RAW_W-1:0] rx, logic [RAW_W-1:0] ry,
                             logic [RAW_W-1:0] rz);
    send_word(pack_frame(OP_SAMPLE, 1'b0, rx, ry, rz, 4'($urandom)));
  endtask

  task automatic send_op(logic [1:0] op, logic err);
    send_word(pack_frame(op, err, RAW_W'($urandom), RAW_W'($urandom), RAW_W'($urandom),
                         4'($urandom)));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [RAW_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
  endtask

  task automatic set_config(bit mode, logic [RAW_W-1:0] ofs);
    wait_drained();
    write_reg(REG_MODE, {(RAW_W-1)'($urandom), mode});
    write_reg(REG_NULL, ofs);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_random_word();
    frame_t f;
    int     pick;
    logic [RAW_W-1:0] ofs;
    pick = $urandom_range(99);
    ofs = sb.null_offset;
    f = pack_frame(OP_SAMPLE, 1'b0, pick_axis(ofs), pick_axis(ofs), pick_axis(ofs),
                   4'($urandom));
    if (pick < 30 && have_last) begin
      f = last_sample;
      f.z_low[3:0] = 4'($urandom);
    end else if (pick >= 30 && pick < 38) begin
      f.bus_error = 1'b1;
    end else if (pick >= 38 && pick < 43) begin
      f.op = OP_CLEAR;
      f.bus_error = 1'($urandom);
    end else if (pick >= 43 && pick < 47) begin
      f.op = OP_FORGET;
      f.bus_error = 1'($urandom);
    end else if (pick >= 47 && pick < 49) begin
      f.op = OP_UNUSED;
      f.bus_error = 1'($urandom);
    end
    send_word(f);
  endtask

  initial begin
    logic [RAW_W-1:0] mid;
    sb = new();
    mid = NULL_OFFSET_RST;
    send_idle_pct = 14;
    recv_idle_pct = 70;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_sample('0, '0, '0);
    send_sample('1, '1, '1);
    send_sample(mid, mid, mid);
    send_sample(mid + 20'd1000, mid, '0);
    send_sample(mid - 20'd1000, mid, '1);
    send_sample(mid, mid + 20'd5000, mid);
    send_sample(mid, mid - 20'd5000, mid);
    send_op(OP_SAMPLE, 1'b1);
    send_sample(mid + 20'd7, mid - 20'd3, mid);
    send_sample(mid + 20'd7, mid - 20'd3, mid);
    send_op(OP_CLEAR, 1'b0);
    send_op(OP_FORGET, 1'b0);
    send_op(OP_UNUSED, 1'b1);

    set_config(1'b1, mid);
    send_sample(mid - 20'd12, mid + 20'd40, mid + 20'd3);
    send_sample(mid - 20'd12, mid + 20'd40, mid + 20'd3);
    send_op(OP_SAMPLE, 1'b1);
    send_word(pack_frame(OP_SAMPLE, 1'b1, mid - 20'd12, mid + 20'd40, mid + 20'd3, 4'd0));
    send_sample(mid - 20'd12, mid + 20'd40, mid + 20'd3);
    send_op(OP_FORGET, 1'b0);
    send_sample(mid - 20'd12, mid + 20'd40, mid + 20'd3);
    send_sample(mid - 20'd12, mid + 20'd40, mid + 20'd3);
    send_op(OP_CLEAR, 1'b1);
    send_sample(mid - 20'd1, mid, mid);
    send_sample(mid, mid, mid);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_config(1'b1, NULL_OFFSET_RST);
        1: set_config(1'b0, '0);
        2: set_config(1'b1, '1);
        3: set_config(1'b1, '0);
        4: set_config(1'b0, RAW_W'($urandom));
        default: set_config(1'b1, RAW_W'($urandom));
      endcase
      send_idle_pct = (phase < 2) ? 14 : (phase < 4) ? 70 : 0;
      recv_idle_pct = (phase < 2) ? 70 : (phase < 4) ? 14 : 0;
      repeat (PHASE_WORDS) send_random_word();
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (sb.pending() != 0) sb.report("expected result words never arrived");
    if (sb.fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
